// File: sv/cosdo_pkg.sv
// Shared types and constants of the CANopen SDO expedited client.
package cosdo_pkg;

    localparam int ID_W    = 11;
    localparam int NODE_W  = 7;
    localparam int TICK_W  = 16;
    localparam int DATA_W  = 32;
    localparam int FRAME_W = 64;

    localparam logic [ID_W-1:0] REQ_BASE_RESET  = 11'h600;
    localparam logic [ID_W-1:0] RESP_BASE_RESET = 11'h580;

    // SDO command specifiers
    localparam logic [7:0] CMD_DOWNLOAD_REQ  = 8'h23;
    localparam logic [7:0] CMD_UPLOAD_REQ    = 8'h40;
    localparam logic [7:0] CMD_DOWNLOAD_RESP = 8'h60;
    localparam logic [7:0] CMD_UPLOAD_RESP   = 8'h40;
    localparam logic [7:0] CMD_ABORT         = 8'h80;
    localparam logic [7:0] CMD_CLASS_MASK    = 8'hE0;
    localparam int         BIT_SIZE_IND      = 0;
    localparam int         BIT_EXPEDITED     = 1;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [3:0]        MIN_DLC  = 4'd8;

    typedef enum logic [1:0] {
        ACT_DOWNLOAD = 2'd0,
        ACT_UPLOAD   = 2'd1,
        ACT_FRAME    = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_ABORTED = 3'd2,
        ST_PROTO   = 3'd3,
        ST_BADARG  = 3'd4
    } t_status;

    typedef enum logic {
        KIND_REQUEST    = 1'b0,
        KIND_COMPLETION = 1'b1
    } t_kind;

    localparam logic CFG_REQ_BASE  = 1'b0;
    localparam logic CFG_RESP_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [NODE_W-1:0]  node_id;
        logic [15:0]        obj_index;
        logic [7:0]         obj_subindex;
        logic [2:0]         write_len;
        logic [DATA_W-1:0]  write_data;
        logic [TICK_W-1:0]  wait_ticks;
        logic [ID_W-1:0]    frame_id;
        logic               frame_extended;
        logic [3:0]         frame_dlc;
        logic [FRAME_W-1:0] frame_payload;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [ID_W-1:0]    tx_id;
        logic [FRAME_W-1:0] tx_payload;
        logic [2:0]         status;
        logic [DATA_W-1:0]  read_data;
        logic [2:0]         read_len;
        logic [DATA_W-1:0]  abort_word;
    } t_out_item;

    // Pending transfer context handed to the response decoder
    typedef struct packed {
        logic               is_upload;
        logic [NODE_W-1:0]  node;
        logic [15:0]        index;
        logic [7:0]         subindex;
        logic               expired;
    } t_pending;

    typedef struct packed {
        logic              hit;
        logic [2:0]        status;
        logic [DATA_W-1:0] read_data;
        logic [2:0]        read_len;
        logic [DATA_W-1:0] abort_word;
    } t_rx_result;

endpackage

// File: sv/cosdo_rx_decode.sv
// Filter and decode of a received SDO response frame.
module cosdo_rx_decode
    import cosdo_pkg::*;
(
    input  logic [ID_W-1:0]    i_resp_base,
    input  t_pending           i_pend,
    input  logic [ID_W-1:0]    i_frame_id,
    input  logic               i_frame_extended,
    input  logic [3:0]         i_frame_dlc,
    input  logic [FRAME_W-1:0] i_frame_payload,
    output t_rx_result         o_rx
);

    logic [7:0]        b0;
    logic [15:0]       ridx;
    logic [7:0]        rsub;
    logic [DATA_W-1:0] hi;
    logic [2:0]        up_len;
    logic [DATA_W-1:0] len_mask;

    assign b0   = i_frame_payload[7:0];
    assign ridx = i_frame_payload[23:8];
    assign rsub = i_frame_payload[31:24];
    assign hi   = i_frame_payload[63:32];

    always_comb begin
        if (b0[BIT_SIZE_IND]) begin
            up_len = 3'd4 - {1'b0, b0[3:2]};
        end else begin
            up_len = 3'd4;
        end
        len_mask = {{8{up_len >= 3'd4}}, {8{up_len >= 3'd3}}, {8{up_len >= 3'd2}}, 8'hFF};
    end

    always_comb begin
        o_rx = '0;
        o_rx.hit = !i_pend.expired && !i_frame_extended && (i_frame_dlc >= MIN_DLC)
                && (i_frame_id == (i_resp_base | {{(ID_W-NODE_W){1'b0}}, i_pend.node}))
                && (ridx == i_pend.index) && (rsub == i_pend.subindex);
        if ((b0 & CMD_CLASS_MASK) == CMD_ABORT) begin
            o_rx.status     = ST_ABORTED;
            o_rx.abort_word = hi;
        end else if (!i_pend.is_upload) begin
            o_rx.status = (b0 == CMD_DOWNLOAD_RESP) ? ST_OK : ST_PROTO;
        end else if (((b0 & CMD_CLASS_MASK) != CMD_UPLOAD_RESP) || !b0[BIT_EXPEDITED]) begin
            o_rx.status = ST_PROTO;
        end else begin
            o_rx.status    = ST_OK;
            o_rx.read_data = hi & len_mask;
            o_rx.read_len  = up_len;
        end
    end

endmodule

// File: sv/canopen_sdo_expedited_client.sv
// Top level of the CANopen SDO expedited transfer client.
//
//  channel   direction  handshake                        payload
//  --------  ---------  -------------------------------  ----------------------
//  input     in         i_in_valid / o_in_ready          i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_ready        o_out_item (t_out_item)
//  config    in         i_cfg_we (no wait)               i_cfg_addr, i_cfg_data
//
// One transaction is taken per cycle. Each is decoded in the cycle it is
// accepted against the transfer state and yields zero or one result, which
// lands in a two-entry registered output queue and is shown once at its head.
// Input stalls only when both queue entries hold results not yet taken.
// Reset (synchronous, active low) clears the transfer state and the queue
// and restores the default request and response identifier bases.
module canopen_sdo_expedited_client
    import cosdo_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [ID_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [ID_W-1:0] r_req_base, r_resp_base;

    // Transfer state
    logic              r_busy, n_busy;
    logic              r_is_upload, n_is_upload;
    logic [NODE_W-1:0] r_node, n_node;
    logic [15:0]       r_index, n_index;
    logic [7:0]        r_subindex, n_subindex;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [TICK_W-1:0] r_limit, n_limit;

    // Output queue
    logic [1:0] r_count, n_count;
    t_out_item  r_q0, n_q0, r_q1, n_q1;

    logic       accept, pop, push;
    t_out_item  res;
    t_pending   pend;
    t_rx_result rx;
    logic [1:0] slot;

    logic [DATA_W-1:0] dl_mask;
    logic [2:0]        len_gap;
    logic [7:0]        cmd;
    logic [DATA_W-1:0] tx_data;
    logic [TICK_W-1:0] tick_next;

    assign o_in_ready  = (r_count != 2'd2);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_item  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_base  <= REQ_BASE_RESET;
            r_resp_base <= RESP_BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REQ_BASE:  r_req_base  <= i_cfg_data;
                CFG_RESP_BASE: r_resp_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pend.is_upload = r_is_upload;
    assign pend.node      = r_node;
    assign pend.index     = r_index;
    assign pend.subindex  = r_subindex;
    assign pend.expired   = (r_elapsed >= r_limit);

    cosdo_rx_decode u_rx_decode (
        .i_resp_base      (r_resp_base),
        .i_pend           (pend),
        .i_frame_id       (i_in_item.frame_id),
        .i_frame_extended (i_in_item.frame_extended),
        .i_frame_dlc      (i_in_item.frame_dlc),
        .i_frame_payload  (i_in_item.frame_payload),
        .o_rx             (rx)
    );

    // Request frame build: command byte, index, subindex, masked download bytes
    always_comb begin
        len_gap = 3'd4 - i_in_item.write_len;
        dl_mask = {{8{i_in_item.write_len >= 3'd4}}, {8{i_in_item.write_len >= 3'd3}},
                   {8{i_in_item.write_len >= 3'd2}}, 8'hFF};
        if (i_in_item.action == ACT_DOWNLOAD) begin
            cmd     = CMD_DOWNLOAD_REQ | {4'b0, len_gap[1:0], 2'b0};
            tx_data = i_in_item.write_data & dl_mask;
        end else begin
            cmd     = CMD_UPLOAD_REQ;
            tx_data = '0;
        end
        tick_next = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    end

    // Transaction decode against the transfer state
    always_comb begin
        n_busy      = r_busy;
        n_is_upload = r_is_upload;
        n_node      = r_node;
        n_index     = r_index;
        n_subindex  = r_subindex;
        n_elapsed   = r_elapsed;
        n_limit     = r_limit;
        push        = 1'b0;
        res         = '0;
        if (accept) begin
            case (i_in_item.action)
                ACT_DOWNLOAD, ACT_UPLOAD: begin
                    // drop a start while a transfer is open
                    if (!r_busy) begin
                        push = 1'b1;
                        if ((i_in_item.action == ACT_DOWNLOAD) &&
                            ((i_in_item.write_len == 3'd0) || (i_in_item.write_len > 3'd4))) begin
                            res.result_kind = KIND_COMPLETION;
                            res.status      = ST_BADARG;
                        end else begin
                            res.result_kind = KIND_REQUEST;
                            res.tx_id       = r_req_base
                                            | {{(ID_W-NODE_W){1'b0}}, i_in_item.node_id};
                            res.tx_payload  = {tx_data, i_in_item.obj_subindex,
                                               i_in_item.obj_index, cmd};
                            n_busy      = 1'b1;
                            n_is_upload = (i_in_item.action == ACT_UPLOAD);
                            n_node      = i_in_item.node_id;
                            n_index     = i_in_item.obj_index;
                            n_subindex  = i_in_item.obj_subindex;
                            n_elapsed   = '0;
                            n_limit     = i_in_item.wait_ticks;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_busy) begin
                        n_elapsed = tick_next;
                        if (tick_next >= r_limit) begin
                            push            = 1'b1;
                            res.result_kind = KIND_COMPLETION;
                            res.status      = ST_TIMEOUT;
                            n_busy          = 1'b0;
                        end
                    end
                end
                ACT_FRAME: begin
                    if (r_busy && rx.hit) begin
                        push            = 1'b1;
                        res.result_kind = KIND_COMPLETION;
                        res.status      = rx.status;
                        res.read_data   = rx.read_data;
                        res.read_len    = rx.read_len;
                        res.abort_word  = rx.abort_word;
                        n_busy          = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output queue: pop shifts the second entry forward, push fills the next free slot
    always_comb begin
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_count = r_count + {1'b0, push} - {1'b0, pop};
        slot    = r_count - {1'b0, pop};
        if (pop) begin
            n_q0 = r_q1;
        end
        if (push) begin
            if (slot == 2'd0) begin
                n_q0 = res;
            end else begin
                n_q1 = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_is_upload <= 1'b0;
            r_node      <= '0;
            r_index     <= '0;
            r_subindex  <= '0;
            r_elapsed   <= '0;
            r_limit     <= '0;
            r_count     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_is_upload <= n_is_upload;
            r_node      <= n_node;
            r_index     <= n_index;
            r_subindex  <= n_subindex;
            r_elapsed   <= n_elapsed;
            r_limit     <= n_limit;
            r_count     <= n_count;
        end
    end

    // Queue payload holds no reset
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule
